@@ sv/pts_pkg.sv @@
// Shared codes and types for the priority thread scheduler.
package pts_pkg;

	localparam int unsigned PTS_THREADS   = 8;
	localparam int unsigned PTS_PRIO_BITS = 8;

	typedef enum logic [1:0] {
		ACT_CREATE   = 2'd0,
		ACT_SIGNAL   = 2'd1,
		ACT_SCHEDULE = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_IDLE    = 2'd2,
		ST_NOSLOT  = 2'd3
	} status_t;

	typedef struct packed {
		logic start;
		logic step;
	} scan_ctl_t;

endpackage

@@ sv/pts_scan.sv @@
// Shared priority comparator: keeps the best ready thread seen during a table scan.
module pts_scan #(
	parameter int unsigned PRIO_BITS = 8,
	parameter int unsigned IDX_W     = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pts_pkg::scan_ctl_t    ctl,
	input  logic [IDX_W-1:0]      idx,
	input  logic [PRIO_BITS-1:0]  prio,
	input  logic                  eligible,
	output logic                  found,
	output logic [IDX_W-1:0]      pick
);
	import pts_pkg::*;

	logic [PRIO_BITS-1:0] best_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 better;

	assign better = eligible && (prio > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
		end else if (ctl.start) begin
			best_q  <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
		end else if (ctl.step && better) begin
			best_q  <= prio;
			found_q <= 1'b1;
			pick_q  <= idx;
		end
	end

	assign found = found_q;
	assign pick  = pick_q;

endmodule

@@ sv/priority_thread_scheduler.sv @@
// Priority thread scheduler: thread table, sequencer and result register.
//
// A create, signal-write or unused-action item goes on to the finish state, where its
// result is loaded into the output register. A schedule item first passes the scan state,
// where the registered table entries pass one per cycle through a single shared priority
// comparator. A result is loaded only once the output register is free or being taken, so
// a stalled output holds the sequencer. After a result is loaded, the sequencer returns to
// rest and can accept the next item, even while that result still waits. Ties in priority
// go to the lowest slot; the main thread (slot 0, priority 0) is never chosen.
module priority_thread_scheduler #(
	parameter int unsigned THREADS   = pts_pkg::PTS_THREADS,
	parameter int unsigned PRIO_BITS = pts_pkg::PTS_PRIO_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] new_prio,
	input  logic [2:0] slot,
	input  logic       signal_flag,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [2:0] thread_index,
	output logic [2:0] previous_index,
	output logic       switched
);
	import pts_pkg::*;

	localparam int unsigned IDX_W = $clog2(THREADS);
	localparam int unsigned CNT_W = $clog2(THREADS + 1);

	typedef enum logic [1:0] {
		S_REST,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [PRIO_BITS-1:0]  prio_q [THREADS];
	logic [THREADS-1:0]    running_q;
	logic [THREADS-1:0]    signal_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      current_q;
	logic [IDX_W-1:0]      idx_q;

	action_t               action_q;
	logic [PRIO_BITS-1:0]  nprio_q;
	logic [2:0]            slot_q;
	logic                  flag_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [2:0]            index_q;
	logic [2:0]            prev_q;
	logic                  switched_q;

	logic                  accept;
	logic                  can_emit;
	logic [PRIO_BITS+7:0]  prio_ext;
	logic [CNT_W+2:0]      slot_ext;
	logic [CNT_W+2:0]      count_ext;
	logic                  slot_bad;
	logic                  table_full;
	logic                  scan_last;
	logic [IDX_W+2:0]      count_idx_ext;
	logic [IDX_W+2:0]      pick_ext;
	logic [IDX_W+2:0]      cur_ext;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	scan_ctl_t             scan_ctl;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_REST);
	assign can_emit   = !out_valid_q || !out_stall;
	assign prio_ext   = {{PRIO_BITS{1'b0}}, new_prio};
	assign slot_ext   = {{CNT_W{1'b0}}, slot_q};
	assign count_ext  = {3'b000, count_q};
	assign slot_bad   = (slot_ext >= count_ext);
	assign table_full = (count_q >= CNT_W'(THREADS));
	assign scan_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign count_idx_ext = {3'b000, count_q[IDX_W-1:0]};
	assign pick_ext   = {3'b000, pick};
	assign cur_ext    = {3'b000, current_q};

	assign scan_ctl.start = accept && (action_t'(action) == ACT_SCHEDULE);
	assign scan_ctl.step  = (state_q == S_SCAN);

	pts_scan #(
		.PRIO_BITS (PRIO_BITS),
		.IDX_W     (IDX_W)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_q),
		.prio     (prio_q[idx_q]),
		.eligible (!running_q[idx_q] && signal_q[idx_q]),
		.found    (found),
		.pick     (pick)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(action);
			nprio_q  <= prio_ext[PRIO_BITS-1:0];
			slot_q   <= slot;
			flag_q   <= signal_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_REST;
			for (int i = 0; i < THREADS; i++) begin
				prio_q[i] <= '0;
			end
			running_q   <= '0;
			signal_q    <= '0;
			count_q     <= CNT_W'(1);
			current_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			index_q     <= '0;
			prev_q      <= '0;
			switched_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_REST: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= (action_t'(action) == ACT_SCHEDULE) ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_FINISH: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						index_q     <= '0;
						prev_q      <= '0;
						switched_q  <= 1'b0;
						unique case (action_q)
							ACT_CREATE: begin
								if (table_full) begin
									status_q <= ST_FULL;
								end else begin
									prio_q[count_q[IDX_W-1:0]]    <= nprio_q;
									running_q[count_q[IDX_W-1:0]] <= 1'b0;
									signal_q[count_q[IDX_W-1:0]]  <= 1'b0;
									count_q  <= count_q + CNT_W'(1);
									index_q  <= count_idx_ext[2:0];
								end
							end
							ACT_SIGNAL: begin
								index_q <= slot_q;
								if (slot_bad) begin
									status_q <= ST_NOSLOT;
								end else begin
									signal_q[slot_ext[IDX_W-1:0]] <= flag_q;
								end
							end
							ACT_SCHEDULE: begin
								if (!found) begin
									status_q <= ST_IDLE;
								end else begin
									running_q[pick]      <= 1'b1;
									running_q[current_q] <= 1'b0;
									current_q  <= pick;
									index_q    <= pick_ext[2:0];
									prev_q     <= cur_ext[2:0];
									switched_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
						state_q <= S_REST;
					end
				end
				default: state_q <= S_REST;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign thread_index   = index_q;
	assign previous_index = prev_q;
	assign switched       = switched_q;

endmodule
